>>> hdl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RES_DATA_W = STATUS_W + 2 * POS_W + COUNT_W;

  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h5D;  // ]
  localparam logic [SYM_W-1:0] CH_RIGHT = 8'h3E;  // >
  localparam logic [SYM_W-1:0] CH_LEFT  = 8'h3C;  // <
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;  // -
  localparam logic [SYM_W-1:0] CH_DOT   = 8'h2E;  // .
  localparam logic [SYM_W-1:0] CH_COMMA = 8'h2C;  // ,

  typedef enum logic [STATUS_W-1:0] {
    ST_PAIR      = 3'd0,
    ST_NO_OPEN   = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_CAPACITY  = 3'd3,
    ST_COMPLETE  = 3'd4
  } bpm_status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } bpm_shift_t;

  typedef struct packed {
    logic               last_result;
    logic [COUNT_W-1:0] command_count;
    logic [POS_W-1:0]   close_position;
    logic [POS_W-1:0]   open_position;
    bpm_status_e        status;
  } bpm_result_t;

  function automatic logic is_command(input logic [SYM_W-1:0] c);
    return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_RIGHT) || (c == CH_LEFT) ||
           (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT) || (c == CH_COMMA);
  endfunction

endpackage

`default_nettype wire

>>> hdl/bpm_cell.sv
`default_nettype none

module bpm_cell (
  input  wire logic                     clk_i,
  input  wire bpm_pkg::bpm_shift_t      shift_i,
  input  wire logic [bpm_pkg::POS_W-1:0] from_up_i,
  input  wire logic [bpm_pkg::POS_W-1:0] from_down_i,
  output logic      [bpm_pkg::POS_W-1:0] value_o
);
  import bpm_pkg::*;

  logic [POS_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (shift_i.push) begin
      value_d = from_up_i;
    end else if (shift_i.pop) begin
      value_d = from_down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> hdl/bpm_result_fifo.sv
`default_nettype none

module bpm_result_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           wr_count_i,   // 0, 1 or 2 entries this cycle
  input  wire bpm_pkg::bpm_result_t wr_first_i,
  input  wire bpm_pkg::bpm_result_t wr_second_i,
  output logic                      room2_o,
  output logic                      rd_valid_o,
  input  wire logic                 rd_ready_i,
  output bpm_pkg::bpm_result_t      rd_data_o
);
  import bpm_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bpm_result_t        mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               rd_fire;

  assign rd_valid_o = (count_q != '0);
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign room2_o    = (count_q <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(wr_count_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(rd_fire);
    count_d  = count_q + CNT_W'(wr_count_i) - CNT_W'(rd_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_count_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_first_i;
    end
    if (wr_count_i == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= wr_second_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bracket_pair_matcher_unit.sv
`default_nettype none

// Bracket pair matcher.
// Input stream: one byte of program text per transaction; tdata = symbol,
// tlast marks the final byte of a program. Bytes other than the eight
// command characters are dropped; the rest are numbered from 0.
// Output stream: tdata = {command_count, close_position, open_position,
// status}, tlast = last_result. Each close bracket gives a pair; errors
// (close without open, capacity) and the end-of-program check give one
// result each, so one input byte yields zero, one or two results.
// Open-bracket positions sit in a shift stack of STACK_DEPTH cells: a push
// moves every cell down one, a pop moves every cell up one, so the top of
// stack is always cell 0 and each byte is at most one push or pop.
// Results are registered in a 4-entry queue on the way to the output.
// Throughput: one byte per cycle while the queue has room; a byte with
// two results sends them out one after the other. s_axis_tready_o
// is high while the queue can take two more, so the input keeps flowing
// while a result waits; a stalled receiver backs up into the input once
// the queue fills. Reset clears the counters, the error flag and the
// queue; stack contents need no clearing.
module bracket_pair_matcher_unit #(
  parameter int unsigned PROGRAM_MAX = 4096,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,   // status, open_position, close_position,
                                             // command_count
  output logic             m_axis_tlast_o    // last_result
);
  import bpm_pkg::*;

  localparam int unsigned CIDX_W = $clog2(PROGRAM_MAX + 1);
  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);

  logic [CIDX_W-1:0] cidx_q, cidx_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic              failed_q, failed_d;

  logic [POS_W-1:0]  cell_val [STACK_DEPTH];
  bpm_shift_t        shift;

  logic              accept, act, cap_err, do_open, do_close, full_err, noopen_err;
  logic              err, failed_now, first_valid, end_valid;
  logic [POS_W-1:0]  pos, top_after;
  logic [LVL_W-1:0]  level_after;
  logic [CIDX_W-1:0] cidx_after;
  bpm_result_t       res_first, res_end, wr_first, wr_second, rd_data;
  logic [1:0]        wr_count;
  logic              room2;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    act        = accept && !failed_q && is_command(s_axis_tdata_i);
    cap_err    = act && (cidx_q == CIDX_W'(PROGRAM_MAX));
    pos        = POS_W'(cidx_q);
    do_open    = act && !cap_err && (s_axis_tdata_i == CH_OPEN);
    do_close   = act && !cap_err && (s_axis_tdata_i == CH_CLOSE);
    full_err   = do_open && (level_q == LVL_W'(STACK_DEPTH));
    noopen_err = do_close && (level_q == '0);
    shift.push = do_open && !full_err;
    shift.pop  = do_close && !noopen_err;
    err        = cap_err || full_err || noopen_err;
    failed_now = failed_q || err;
    first_valid = err || shift.pop;

    cidx_after  = cidx_q + CIDX_W'(act && !cap_err);
    level_after = level_q + LVL_W'(shift.push) - LVL_W'(shift.pop);
    if (shift.push) begin
      top_after = pos;
    end else if (shift.pop) begin
      top_after = cell_val[1];
    end else begin
      top_after = cell_val[0];
    end

    res_first = '0;
    if (cap_err || full_err) begin
      res_first.status      = ST_CAPACITY;
      res_first.last_result = s_axis_tlast_i;
    end else if (noopen_err) begin
      res_first.status         = ST_NO_OPEN;
      res_first.close_position = pos;
      res_first.last_result    = s_axis_tlast_i;
    end else begin
      res_first.status         = ST_PAIR;
      res_first.open_position  = cell_val[0];
      res_first.close_position = pos;
    end

    end_valid = accept && s_axis_tlast_i && !failed_now;
    res_end   = '0;
    res_end.last_result = 1'b1;
    if (level_after != '0) begin
      res_end.status        = ST_UNMATCHED;
      res_end.open_position = top_after;
    end else begin
      res_end.status        = ST_COMPLETE;
      res_end.command_count = COUNT_W'(cidx_after);
    end

    wr_count  = 2'(first_valid) + 2'(end_valid);
    wr_first  = first_valid ? res_first : res_end;
    wr_second = res_end;

    cidx_d   = cidx_q;
    level_d  = level_q;
    failed_d = failed_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        cidx_d   = '0;
        level_d  = '0;
        failed_d = 1'b0;
      end else begin
        cidx_d   = cidx_after;
        level_d  = level_after;
        failed_d = failed_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cidx_q   <= '0;
      level_q  <= '0;
      failed_q <= 1'b0;
    end else begin
      cidx_q   <= cidx_d;
      level_q  <= level_d;
      failed_q <= failed_d;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [POS_W-1:0] up_val, down_val;
    if (i == 0) begin : g_top
      assign up_val = pos;
    end else begin : g_mid
      assign up_val = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_val = '0;
    end else begin : g_rest
      assign down_val = cell_val[i+1];
    end
    bpm_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .from_up_i   (up_val),
      .from_down_i (down_val),
      .value_o     (cell_val[i])
    );
  end

  bpm_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_count_i  (wr_count),
    .wr_first_i  (wr_first),
    .wr_second_i (wr_second),
    .room2_o     (room2),
    .rd_valid_o  (m_axis_tvalid_o),
    .rd_ready_i  (m_axis_tready_i),
    .rd_data_o   (rd_data)
  );

  assign s_axis_tready_o = room2;
  assign m_axis_tdata_o  = {rd_data.command_count, rd_data.close_position,
                            rd_data.open_position, rd_data.status};
  assign m_axis_tlast_o  = rd_data.last_result;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  import bpm_pkg::*;

  localparam int unsigned PROGRAM_MAX  = 4096;
  localparam int unsigned STACK_DEPTH  = 256;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned MAX_REPORTS  = 30;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_JITTER,
    RX_HOLD
  } rx_mode_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  bracket_pair_matcher_unit #(
    .PROGRAM_MAX(PROGRAM_MAX),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic bit is_command_char(input logic [7:0] ch);
    case (ch)
      CH_OPEN, CH_CLOSE, CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Tracks command numbering and the open-bracket stack, queues the match
  // results each byte should produce, and checks the output stream against them.
  class BracketMatchModel;
    logic [COUNT_W-1:0] cmd_index;
    logic [POS_W-1:0]   open_stack [STACK_DEPTH];
    logic [8:0]         level;
    bit                 failed;
    bpm_result_t        expected_matches [$];
    int unsigned        errors;

    function new();
      cmd_index = '0;
      level     = '0;
      failed    = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    function void queue_match(input bpm_status_e st, input logic [POS_W-1:0] op,
                              input logic [POS_W-1:0] cp, input logic [COUNT_W-1:0] cnt,
                              input logic lastr);
      bpm_result_t r;
      r.status         = st;
      r.open_position  = op;
      r.close_position = cp;
      r.command_count  = cnt;
      r.last_result    = lastr;
      expected_matches.push_back(r);
    endfunction

    function void take_byte(input logic [7:0] sym, input logic last);
      logic [POS_W-1:0] pos;
      if (!failed && is_command_char(sym)) begin
        if (cmd_index >= PROGRAM_MAX) begin
          queue_match(ST_CAPACITY, '0, '0, '0, last);
          failed = 1'b1;
        end else begin
          pos = cmd_index[POS_W-1:0];
          cmd_index++;
          if (sym == CH_OPEN) begin
            if (level >= STACK_DEPTH) begin
              queue_match(ST_CAPACITY, '0, '0, '0, last);
              failed = 1'b1;
            end else begin
              open_stack[level[7:0]] = pos;
              level++;
            end
          end else if (sym == CH_CLOSE) begin
            if (level == 0) begin
              queue_match(ST_NO_OPEN, '0, pos, '0, last);
              failed = 1'b1;
            end else begin
              level--;
              queue_match(ST_PAIR, open_stack[level[7:0]], pos, '0, 1'b0);
            end
          end
        end
      end
      if (last) begin
        if (!failed) begin
          if (level != 0)
            queue_match(ST_UNMATCHED, open_stack[8'(level - 9'd1)], '0, '0, 1'b1);
          else queue_match(ST_COMPLETE, '0, '0, cmd_index, 1'b1);
        end
        cmd_index = '0;
        level     = '0;
        failed    = 1'b0;
      end
    endfunction

    function void report_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endfunction

    function void check_match(input logic [39:0] data, input logic lastr);
      bpm_result_t want;
      if (expected_matches.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                   $time, data, lastr);
        return;
      end
      want = expected_matches.pop_front();
      if (data[2:0] !== want.status)
        report_field("status", 13'(want.status), 13'(data[2:0]));
      if (data[14:3] !== want.open_position)
        report_field("open_position", 13'(want.open_position), 13'(data[14:3]));
      if (data[26:15] !== want.close_position)
        report_field("close_position", 13'(want.close_position), 13'(data[26:15]));
      if (data[39:27] !== want.command_count)
        report_field("command_count", want.command_count, data[39:27]);
      if (lastr !== want.last_result)
        report_field("last_result", 13'(want.last_result), 13'(lastr));
    endfunction
  endclass

  BracketMatchModel model = new();

  logic [7:0]  cmd_chars [8] = '{CH_OPEN, CH_CLOSE, CH_RIGHT, CH_LEFT,
                                 CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA};
  logic [7:0]  program_text [$];
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_left = 0;
  rx_mode_e    ready_mode = RX_FLOW;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, model.pending());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: runs of steady flow, per-cycle jitter, and hard stalls.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          ready_mode = RX_FLOW;
          ready_left = $urandom_range(1, 60);
        end
        3, 4, 5, 6: begin
          ready_mode = RX_JITTER;
          ready_left = $urandom_range(1, 30);
        end
        default: begin
          ready_mode = RX_HOLD;
          ready_left = $urandom_range(1, 12);
        end
      endcase
    end
    ready_left--;
    case (ready_mode)
      RX_FLOW:   m_axis_tready_i <= 1'b1;
      RX_JITTER: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default:   m_axis_tready_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) model.take_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) model.check_match(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Called at a rising edge; returns at the edge where the byte is taken.
  task automatic send_byte(input logic [7:0] sym, input logic last);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(50, 200);
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
  endtask

  task automatic send_text();
    foreach (program_text[i]) send_byte(program_text[i], i == program_text.size() - 1);
  endtask

  function automatic logic [7:0] plain_command();
    return cmd_chars[$urandom_range(2, 7)];
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == CH_OPEN || ch == CH_CLOSE) ch ^= 8'h01;
    return ch;
  endfunction

  // Mostly balanced programs with random filler; some broken or pure noise.
  task automatic build_random_program();
    int unsigned len, style, depth, roll;
    program_text.delete();
    len   = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    style = $urandom_range(0, 9);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (style == 9) begin
        program_text.push_back(8'($urandom_range(0, 255)));
      end else if (style >= 7) begin
        if (roll < 40) program_text.push_back(cmd_chars[$urandom_range(0, 1)]);
        else if (roll < 80) program_text.push_back(plain_command());
        else program_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (depth > 0 && roll < 25) begin
          program_text.push_back(CH_CLOSE);
          depth--;
        end else if (roll < 50) begin
          program_text.push_back(CH_OPEN);
          depth++;
        end else if (roll < 85) begin
          program_text.push_back(plain_command());
        end else begin
          program_text.push_back(noise_byte());
        end
      end
    end
    if (style < 7) begin
      while (depth > 0) begin
        program_text.push_back(CH_CLOSE);
        depth--;
      end
    end
  endtask

  task automatic run_directed();
    // empty program, only a non-command byte
    program_text = '{8'h00};
    send_text();
    // close without open, then everything ignored through the last byte
    program_text = '{8'hFF, CH_CLOSE, CH_PLUS, CH_OPEN};
    send_text();
    // all eight commands, pair on the last byte then completion
    program_text = '{CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA,
                     CH_OPEN, 8'h41, CH_CLOSE};
    send_text();
    // pair on the last byte followed by an unmatched open
    program_text = '{CH_OPEN, CH_OPEN, CH_CLOSE};
    send_text();
    // error on the last byte
    program_text = '{CH_CLOSE};
    send_text();
    program_text = '{CH_OPEN};
    send_text();
    program_text = '{8'h7F, 8'h80};
    send_text();
  endtask

  task automatic run_capacity();
    // full command range with a full-depth nest closing on the last byte
    for (int i = 0; i < PROGRAM_MAX - 2 * STACK_DEPTH; i++) send_byte(plain_command(), 1'b0);
    for (int i = 0; i < STACK_DEPTH; i++) send_byte(CH_OPEN, 1'b0);
    for (int i = 0; i < STACK_DEPTH; i++) send_byte(CH_CLOSE, i == STACK_DEPTH - 1);
    // stack full, open on the last slot left unmatched
    for (int i = 0; i < STACK_DEPTH; i++) send_byte(CH_OPEN, i == STACK_DEPTH - 1);
    // stack overflow, then trailing bytes ignored
    for (int i = 0; i <= STACK_DEPTH; i++) send_byte(CH_OPEN, 1'b0);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), i == 4);
    // one command past the limit, arriving as the last byte
    for (int i = 0; i < PROGRAM_MAX; i++) send_byte(plain_command(), 1'b0);
    send_byte(CH_CLOSE, 1'b1);
  endtask

  initial begin
    int unsigned random_sent;
    random_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_capacity();
    while (random_sent < RANDOM_ITEMS) begin
      build_random_program();
      foreach (program_text[i])
        if (is_command_char(program_text[i])) random_sent++;
      send_text();
    end
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (model.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, model.pending());
    if (model.errors == 0 && model.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/bpm_pkg.sv
hdl/bpm_cell.sv
hdl/bpm_result_fifo.sv
hdl/bracket_pair_matcher_unit.sv
sim/testbench.sv
